[sv/btc_pkg.sv]
// shared types, constants and saturation helpers for the bone transform composer
package btc_pkg;

    // default fixed-point and cordic settings
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // cordic number formats
    localparam int ANG_FRAC     = 32;
    localparam int TRIG_FRAC    = 30;
    localparam int Z_W          = 42;
    localparam int T_W          = 33;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [T_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in degrees, 32 fractional bits
    localparam logic [39:0] ATAN_DEG [ATAN_ENTRIES] = '{
        40'd193273528320, 40'd114096026022, 40'd60285206653, 40'd30601712202,
        40'd15360239180,  40'd7687607525,   40'd3844741810,  40'd1922488225,
        40'd961258780,    40'd480631223,    40'd240315841,   40'd120157949,
        40'd60078978,     40'd30039489,     40'd15019745,    40'd7509872,
        40'd3754936,      40'd1877468,      40'd938734,      40'd469367,
        40'd234684,       40'd117342,       40'd58671,       40'd29335
    };

    // modulo-360 reduction: 360 = 45 * 8, the 45 part by reciprocal multiply
    localparam int RED_DIV    = 45;
    localparam int RED_OFFSET = 92160;   // 45 * 2048, keeps the high part non-negative
    localparam int RED_MUL    = 372827;  // (2^24 - 1) / 45
    localparam int RED_SHIFT  = 24;
    localparam int RED_W      = 18;
    localparam int RED_MUL_W  = 19;

    // spin direction codes
    localparam logic signed [1:0] SPIN_NEG  = 2'sb11;
    localparam logic signed [1:0] SPIN_ZERO = 2'sb00;
    localparam logic signed [1:0] SPIN_POS  = 2'sb01;

    // payload that travels beside the cordic
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [26:0] angle;
        logic signed [26:0] rot;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [1:0]  spin;
        logic               neg;
    } pass_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return $signed(v[31:0]);
    endfunction

    function automatic logic signed [26:0] sat27(input logic signed [63:0] v);
        if (v > 64'sd67108863)
        begin
            return 27'sh3ffffff;
        end
        else if (v < -64'sd67108864)
        begin
            return 27'sh4000000;
        end
        return $signed(v[26:0]);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
        begin
            return 24'sh7fffff;
        end
        else if (v < -64'sd8388608)
        begin
            return 24'sh800000;
        end
        return $signed(v[23:0]);
    endfunction

endpackage

[sv/btc_front.sv]
// front pipeline: scale products, angle sums and reduction of the rotation angle
module btc_front #(
    parameter int FRAC_BITS = btc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [31:0]             child_x,
    input  logic signed [31:0]             child_y,
    input  logic signed [26:0]             child_angle,
    input  logic signed [23:0]             child_scale_x,
    input  logic signed [23:0]             child_scale_y,
    input  logic signed [26:0]             child_rot_total,
    input  logic signed [31:0]             parent_x,
    input  logic signed [31:0]             parent_y,
    input  logic signed [26:0]             parent_angle,
    input  logic signed [23:0]             parent_scale_x,
    input  logic signed [23:0]             parent_scale_y,
    input  logic signed [26:0]             parent_rot_total,
    output logic                           valid_out,
    output logic signed [btc_pkg::Z_W-1:0] z_out,
    output btc_pkg::pass_t                 pass_out
);
    import btc_pkg::*;

    localparam int HW = 25 - FRAC_BITS;   // angle bits above the 8-degree boundary
    localparam int LW = FRAC_BITS + 3;
    localparam int RW = FRAC_BITS + 10;
    localparam logic signed [56:0] HALF_P = 57'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [48:0] HALF_S = 49'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] FULL_A = RW'(360) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] HALF_A = RW'(180) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] QTR_A  = RW'(90) <<< FRAC_BITS;

    // stage 1
    logic                      v1_reg;
    logic signed [55:0]        pcx_reg, pcy_reg;
    logic signed [47:0]        pscx_reg, pscy_reg;
    logic signed [31:0]        px1_reg, py1_reg;
    logic signed [26:0]        ang1_reg, rot1_reg;
    logic signed [1:0]         spin1_reg;
    logic signed [27:0]        a1_reg;
    logic                      flip;
    logic signed [27:0]        pa_ext, a_next, ang_sum, rot_sum;
    logic signed [26:0]        rot_sat;

    // stage 2
    logic                      v2_reg;
    logic signed [31:0]        sx2_reg, sy2_reg, px2_reg, py2_reg;
    logic signed [23:0]        scx2_reg, scy2_reg;
    logic signed [26:0]        ang2_reg, rot2_reg;
    logic signed [1:0]         spin2_reg;
    logic [RED_W-1:0]          hu2_reg;
    logic [RED_W+RED_MUL_W-1:0] prod2_reg;
    logic [LW-1:0]             lo2_reg;
    logic signed [56:0]        tx, ty;
    logic signed [48:0]        tsx, tsy;
    logic signed [HW-1:0]      hi_part;
    logic [RED_W-1:0]          hu;

    // stage 3
    logic                      v3_reg;
    pass_t                     pass3_reg;
    logic [5:0]                rem3_reg;
    logic [LW-1:0]             lo3_reg;
    logic [12:0]               q;
    logic [RED_W-1:0]          q45, rem_w;

    // stage 4
    logic                      v4_reg;
    pass_t                     pass4_reg, pass4_next;
    logic signed [Z_W-1:0]     z4_reg;
    logic signed [RW-1:0]      r0, r1, r2;
    logic                      neg;

    // stage 1 logic
    always_comb
    begin
        flip    = parent_scale_x[23] ^ parent_scale_y[23];
        pa_ext  = 28'(parent_angle);
        a_next  = flip ? -pa_ext : pa_ext;
        ang_sum = 28'(child_angle) + 28'(parent_angle);
        rot_sum = 28'(child_rot_total) + 28'(parent_rot_total);
        rot_sat = sat27(64'(rot_sum));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pcx_reg  <= 56'(child_x) * 56'(parent_scale_x);
        pcy_reg  <= 56'(child_y) * 56'(parent_scale_y);
        pscx_reg <= 48'(child_scale_x) * 48'(parent_scale_x);
        pscy_reg <= 48'(child_scale_y) * 48'(parent_scale_y);
        px1_reg  <= parent_x;
        py1_reg  <= parent_y;
        ang1_reg <= sat27(64'(ang_sum));
        rot1_reg <= rot_sat;
        if (rot_sat[26])
        begin
            spin1_reg <= SPIN_NEG;
        end
        else if (rot_sat == '0)
        begin
            spin1_reg <= SPIN_ZERO;
        end
        else
        begin
            spin1_reg <= SPIN_POS;
        end
        a1_reg <= a_next;
    end

    // stage 2 logic: rounding of products, reciprocal multiply for mod 45
    always_comb
    begin
        tx      = (57'(pcx_reg) + HALF_P) >>> FRAC_BITS;
        ty      = (57'(pcy_reg) + HALF_P) >>> FRAC_BITS;
        tsx     = (49'(pscx_reg) + HALF_S) >>> FRAC_BITS;
        tsy     = (49'(pscy_reg) + HALF_S) >>> FRAC_BITS;
        hi_part = a1_reg[27:LW];
        hu      = RED_W'(hi_part) + RED_W'(RED_OFFSET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx2_reg   <= sat32(64'(tx));
        sy2_reg   <= sat32(64'(ty));
        scx2_reg  <= sat24(64'(tsx));
        scy2_reg  <= sat24(64'(tsy));
        px2_reg   <= px1_reg;
        py2_reg   <= py1_reg;
        ang2_reg  <= ang1_reg;
        rot2_reg  <= rot1_reg;
        spin2_reg <= spin1_reg;
        hu2_reg   <= hu;
        prod2_reg <= (RED_W+RED_MUL_W)'(hu) * (RED_W+RED_MUL_W)'(RED_MUL);
        lo2_reg   <= a1_reg[LW-1:0];
    end

    // stage 3 logic: remainder with one correction step
    always_comb
    begin
        q     = prod2_reg[RED_SHIFT+12:RED_SHIFT];
        q45   = RED_W'(q) * RED_W'(RED_DIV);
        rem_w = hu2_reg - q45;
        if (rem_w >= RED_W'(RED_DIV))
        begin
            rem_w = rem_w - RED_W'(RED_DIV);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pass3_reg.sx      <= sx2_reg;
        pass3_reg.sy      <= sy2_reg;
        pass3_reg.px      <= px2_reg;
        pass3_reg.py      <= py2_reg;
        pass3_reg.angle   <= ang2_reg;
        pass3_reg.rot     <= rot2_reg;
        pass3_reg.scale_x <= scx2_reg;
        pass3_reg.scale_y <= scy2_reg;
        pass3_reg.spin    <= spin2_reg;
        pass3_reg.neg     <= 1'b0;
        rem3_reg          <= rem_w[5:0];
        lo3_reg           <= lo2_reg;
    end

    // stage 4 logic: fold into [-90, 90] and rescale to cordic angle format
    always_comb
    begin
        r0  = $signed({1'b0, rem3_reg, lo3_reg});
        r1  = (r0 >= HALF_A) ? r0 - FULL_A : r0;
        r2  = r1;
        neg = 1'b0;
        if (r1 > QTR_A)
        begin
            r2  = r1 - HALF_A;
            neg = 1'b1;
        end
        else if (r1 < -QTR_A)
        begin
            r2  = r1 + HALF_A;
            neg = 1'b1;
        end
        pass4_next     = pass3_reg;
        pass4_next.neg = neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z4_reg    <= Z_W'(r2) <<< (ANG_FRAC - FRAC_BITS);
        pass4_reg <= pass4_next;
    end

    assign valid_out = v4_reg;
    assign z_out     = z4_reg;
    assign pass_out  = pass4_reg;

endmodule

[sv/btc_cell.sv]
// one cordic rotation step, registered, with the payload carried alongside
module btc_cell #(
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [btc_pkg::T_W-1:0] x_in,
    input  logic signed [btc_pkg::T_W-1:0] y_in,
    input  logic signed [btc_pkg::Z_W-1:0] z_in,
    input  btc_pkg::pass_t                 pass_in,
    output logic                           valid_out,
    output logic signed [btc_pkg::T_W-1:0] x_out,
    output logic signed [btc_pkg::T_W-1:0] y_out,
    output logic signed [btc_pkg::Z_W-1:0] z_out,
    output btc_pkg::pass_t                 pass_out
);
    import btc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_Z = $signed({2'b00, ATAN_DEG[IDX]});

    logic                  valid_reg;
    logic signed [T_W-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [Z_W-1:0] z_reg, z_next;
    pass_t                 pass_reg;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        // non-negative residual rotates forward
        if (!z_in[Z_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_Z;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        pass_reg <= pass_in;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign pass_out  = pass_reg;

endmodule

[sv/btc_back.sv]
// back pipeline: rotate the scaled position, add the origin, saturate, drive results
module btc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [btc_pkg::T_W-1:0] cos_in,
    input  logic signed [btc_pkg::T_W-1:0] sin_in,
    input  btc_pkg::pass_t                 pass_in,
    output logic                           done,
    output logic signed [31:0]             out_x,
    output logic signed [31:0]             out_y,
    output logic signed [26:0]             out_angle,
    output logic signed [23:0]             out_scale_x,
    output logic signed [23:0]             out_scale_y,
    output logic signed [26:0]             out_rot_total,
    output logic signed [1:0]              spin_dir
);
    import btc_pkg::*;

    localparam int P_W = 32 + T_W;
    localparam int D_W = P_W + 1;
    localparam logic signed [D_W-1:0] RND = D_W'(1) <<< (TRIG_FRAC - 1);

    logic                  v1_reg, v2_reg, v3_reg, done_reg;
    logic signed [T_W-1:0] c1_reg, s1_reg;
    pass_t                 pass1_reg, pass2_reg, pass3_reg;
    logic signed [P_W-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [D_W-1:0] dx3_reg, dy3_reg, tx_full, ty_full;
    logic signed [36:0]    sum_x, sum_y;

    logic signed [31:0]    out_x_reg, out_y_reg;
    logic signed [26:0]    out_angle_reg, out_rot_reg;
    logic signed [23:0]    out_scale_x_reg, out_scale_y_reg;
    logic signed [1:0]     spin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= valid_in;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // quadrant fold undone by negating both
    always_ff @(posedge clk)
    begin
        c1_reg    <= pass_in.neg ? -cos_in : cos_in;
        s1_reg    <= pass_in.neg ? -sin_in : sin_in;
        pass1_reg <= pass_in;
    end

    always_ff @(posedge clk)
    begin
        pxc_reg   <= P_W'(pass1_reg.sx) * P_W'(c1_reg);
        pys_reg   <= P_W'(pass1_reg.sy) * P_W'(s1_reg);
        pxs_reg   <= P_W'(pass1_reg.sx) * P_W'(s1_reg);
        pyc_reg   <= P_W'(pass1_reg.sy) * P_W'(c1_reg);
        pass2_reg <= pass1_reg;
    end

    always_ff @(posedge clk)
    begin
        dx3_reg   <= D_W'(pxc_reg) - D_W'(pys_reg);
        dy3_reg   <= D_W'(pxs_reg) + D_W'(pyc_reg);
        pass3_reg <= pass2_reg;
    end

    always_comb
    begin
        tx_full = (dx3_reg + RND) >>> TRIG_FRAC;
        ty_full = (dy3_reg + RND) >>> TRIG_FRAC;
        sum_x   = 37'($signed(tx_full[35:0])) + 37'(pass3_reg.px);
        sum_y   = 37'($signed(ty_full[35:0])) + 37'(pass3_reg.py);
    end

    always_ff @(posedge clk)
    begin
        out_x_reg       <= sat32(64'(sum_x));
        out_y_reg       <= sat32(64'(sum_y));
        out_angle_reg   <= pass3_reg.angle;
        out_rot_reg     <= pass3_reg.rot;
        out_scale_x_reg <= pass3_reg.scale_x;
        out_scale_y_reg <= pass3_reg.scale_y;
        spin_reg        <= pass3_reg.spin;
    end

    assign done          = done_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_angle     = out_angle_reg;
    assign out_scale_x   = out_scale_x_reg;
    assign out_scale_y   = out_scale_y_reg;
    assign out_rot_total = out_rot_reg;
    assign spin_dir      = spin_reg;

endmodule

[sv/bone_transform_compose.sv]
// top level of the 2d bone transform composer: front pipeline, cordic chain, back pipeline
//
// Fully pipelined: a request is taken on every clock edge where start is high
// (busy is always low), and its result appears on the result ports, with done
// high, for exactly one cycle. The path runs through the scale products and
// angle reduction in front, the cordic chain, one cell per stage (16 stages by
// default, capped at the size of the arctangent table), and the rotation
// multiply, add and saturation behind it. Results are strictly in request
// order and the receiver must take each one in the cycle it is shown.
module bone_transform_compose #(
    parameter int FRAC_BITS     = btc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = btc_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] child_x,
    input  logic signed [31:0] child_y,
    input  logic signed [26:0] child_angle,
    input  logic signed [23:0] child_scale_x,
    input  logic signed [23:0] child_scale_y,
    input  logic signed [26:0] child_rot_total,
    input  logic signed [31:0] parent_x,
    input  logic signed [31:0] parent_y,
    input  logic signed [26:0] parent_angle,
    input  logic signed [23:0] parent_scale_x,
    input  logic signed [23:0] parent_scale_y,
    input  logic signed [26:0] parent_rot_total,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [26:0] out_angle,
    output logic signed [23:0] out_scale_x,
    output logic signed [23:0] out_scale_y,
    output logic signed [26:0] out_rot_total,
    output logic signed [1:0]  spin_dir
);
    import btc_pkg::*;

    // stages past the end of the arctangent table are not built
    localparam int NCELLS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int LATENCY = 8 + NCELLS;

    // cordic chain taps: index k is the input of cell k
    logic                  chain_valid [NCELLS+1];
    logic signed [T_W-1:0] chain_x     [NCELLS+1];
    logic signed [T_W-1:0] chain_y     [NCELLS+1];
    logic signed [Z_W-1:0] chain_z     [NCELLS+1];
    pass_t                 chain_pass  [NCELLS+1];

    // no backpressure anywhere, so a request is always taken
    assign busy = 1'b0;

    // scale products, angle and rotation sums, spin, and angle reduction
    btc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .valid_in         (start),
        .child_x          (child_x),
        .child_y          (child_y),
        .child_angle      (child_angle),
        .child_scale_x    (child_scale_x),
        .child_scale_y    (child_scale_y),
        .child_rot_total  (child_rot_total),
        .parent_x         (parent_x),
        .parent_y         (parent_y),
        .parent_angle     (parent_angle),
        .parent_scale_x   (parent_scale_x),
        .parent_scale_y   (parent_scale_y),
        .parent_rot_total (parent_rot_total),
        .valid_out        (chain_valid[0]),
        .z_out            (chain_z[0]),
        .pass_out         (chain_pass[0])
    );

    // cordic starts with the gain-compensated unit vector on the x axis
    assign chain_x[0] = CORDIC_GAIN;
    assign chain_y[0] = '0;

    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        btc_cell #(
            .IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[k]),
            .x_in      (chain_x[k]),
            .y_in      (chain_y[k]),
            .z_in      (chain_z[k]),
            .pass_in   (chain_pass[k]),
            .valid_out (chain_valid[k+1]),
            .x_out     (chain_x[k+1]),
            .y_out     (chain_y[k+1]),
            .z_out     (chain_z[k+1]),
            .pass_out  (chain_pass[k+1])
        );
    end

    // rotation by (cos, sin), origin add and output registers
    btc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (chain_valid[NCELLS]),
        .cos_in        (chain_x[NCELLS]),
        .sin_in        (chain_y[NCELLS]),
        .pass_in       (chain_pass[NCELLS]),
        .done          (done),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_angle     (out_angle),
        .out_scale_x   (out_scale_x),
        .out_scale_y   (out_scale_y),
        .out_rot_total (out_rot_total),
        .spin_dir      (spin_dir)
    );

endmodule

[sv/btc_checker.sv]
// port-level checker for the bone transform composer, bound to the top level
module btc_checker #(
    parameter int LATENCY = 24
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [26:0] out_rot_total,
    input logic signed [1:0]  spin_dir
);
    import btc_pkg::*;

    // no result may be shown while reset is held
    a_no_done_in_reset: assert property (@(posedge clk) !rst_n |-> !done)
        else $error("result strobe during reset");

    // every result comes from a request a fixed latency earlier
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching request");

    // every request yields its result after the fixed latency
    a_request_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request lost");

    // spin direction agrees with the sign of the summed rotation
    a_spin_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((out_rot_total[26] == (spin_dir == SPIN_NEG))
                  && ((out_rot_total == '0) == (spin_dir == SPIN_ZERO))
                  && (spin_dir != 2'sb10)))
        else $error("spin direction does not match rotation sum");

endmodule

bind bone_transform_compose btc_checker #(
    .LATENCY (LATENCY)
) u_btc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .out_rot_total (out_rot_total),
    .spin_dir      (spin_dir)
);

[tb/sv/compose_checker.sv]
// checker for the bone transform composer: predicts each composed pose and compares results
`timescale 1ns / 1ps

module compose_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] child_x,
    input  logic signed [31:0] child_y,
    input  logic signed [26:0] child_angle,
    input  logic signed [23:0] child_scale_x,
    input  logic signed [23:0] child_scale_y,
    input  logic signed [26:0] child_rot_total,
    input  logic signed [31:0] parent_x,
    input  logic signed [31:0] parent_y,
    input  logic signed [26:0] parent_angle,
    input  logic signed [23:0] parent_scale_x,
    input  logic signed [23:0] parent_scale_y,
    input  logic signed [26:0] parent_rot_total,
    input  logic               done,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [26:0] out_angle,
    input  logic signed [23:0] out_scale_x,
    input  logic signed [23:0] out_scale_y,
    input  logic signed [26:0] out_rot_total,
    input  logic signed [1:0]  spin_dir,
    output int                 mismatches,
    output int                 pending
);
    import btc_pkg::*;

    localparam int FRAC       = 16;
    localparam int STAGES     = 16;
    localparam int ANGLE_FRAC = 32;
    localparam int UNIT_FRAC  = 30;
    localparam longint GAIN   = 652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [26:0] angle;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [26:0] rot;
        logic signed [1:0]  spin;
    } pose_t;

    pose_t pose_q[$];

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // add half an lsb, then floor
    function automatic longint round_down(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // atan(2^-i) in degrees, 32 fractional bits
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 64'd193273528320;
            1:  return 64'd114096026022;
            2:  return 64'd60285206653;
            3:  return 64'd30601712202;
            4:  return 64'd15360239180;
            5:  return 64'd7687607525;
            6:  return 64'd3844741810;
            7:  return 64'd1922488225;
            8:  return 64'd961258780;
            9:  return 64'd480631223;
            10: return 64'd240315841;
            11: return 64'd120157949;
            12: return 64'd60078978;
            13: return 64'd30039489;
            14: return 64'd15019745;
            15: return 64'd7509872;
            16: return 64'd3754936;
            17: return 64'd1877468;
            18: return 64'd938734;
            19: return 64'd469367;
            20: return 64'd234684;
            21: return 64'd117342;
            22: return 64'd58671;
            default: return 64'd29335;
        endcase
    endfunction

    function automatic void unit_vector(input longint ang, output longint sin_v,
                                        output longint cos_v);
        longint full;
        longint half;
        longint quarter;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     neg;
        int     i;
        full    = longint'(360) <<< FRAC;
        half    = longint'(180) <<< FRAC;
        quarter = longint'(90) <<< FRAC;
        neg     = 1'b0;
        r = ang % full;
        if (r < 0)
        begin
            r += full;
        end
        if (r >= half)
        begin
            r -= full;
        end
        // fold into the right half plane, negate sin and cos afterwards
        if (r > quarter)
        begin
            r -= half;
            neg = 1'b1;
        end
        else if (r < -quarter)
        begin
            r += half;
            neg = 1'b1;
        end
        z = r <<< (ANGLE_FRAC - FRAC);
        x = GAIN;
        y = 0;
        for (i = 0; i < STAGES && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        sin_v = neg ? -y : y;
        cos_v = neg ? -x : x;
    endfunction

    function automatic pose_t predict_pose(
        input longint cx, input longint cy, input longint ca,
        input longint csx, input longint csy, input longint crt,
        input longint px, input longint py, input longint pa,
        input longint psx, input longint psy, input longint prt);
        pose_t  p;
        longint sx;
        longint sy;
        longint s;
        longint c;
        longint rot;
        bit     flip;
        sx = clamp(round_down(cx * psx, FRAC), 32);
        sy = clamp(round_down(cy * psy, FRAC), 32);
        // mirrored parent turns the other way
        flip = (psx < 0) != (psy < 0);
        unit_vector(flip ? -pa : pa, s, c);
        rot       = clamp(crt + prt, 27);
        p.x       = 32'(clamp(round_down(sx * c - sy * s, UNIT_FRAC) + px, 32));
        p.y       = 32'(clamp(round_down(sx * s + sy * c, UNIT_FRAC) + py, 32));
        p.angle   = 27'(clamp(ca + pa, 27));
        p.scale_x = 24'(clamp(round_down(csx * psx, FRAC), 24));
        p.scale_y = 24'(clamp(round_down(csy * psy, FRAC), 24));
        p.rot     = 27'(rot);
        p.spin    = (rot < 0) ? SPIN_NEG : ((rot == 0) ? SPIN_ZERO : SPIN_POS);
        return p;
    endfunction

    always @(posedge clk)
    begin
        pose_t want;
        pose_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pose_q.push_back(predict_pose(child_x, child_y, child_angle,
                    child_scale_x, child_scale_y, child_rot_total,
                    parent_x, parent_y, parent_angle,
                    parent_scale_x, parent_scale_y, parent_rot_total));
            end
            if (done)
            begin
                got = '{out_x, out_y, out_angle, out_scale_x, out_scale_y,
                        out_rot_total, spin_dir};
                if (pose_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result x=%0d y=%0d", out_x, out_y);
                    end
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"mismatch exp x=%0d y=%0d ang=%0d sx=%0d",
                                      " sy=%0d rot=%0d spin=%0d"},
                                     want.x, want.y, want.angle, want.scale_x,
                                     want.scale_y, want.rot, want.spin);
                            $display({"         got x=%0d y=%0d ang=%0d sx=%0d",
                                      " sy=%0d rot=%0d spin=%0d"},
                                     got.x, got.y, got.angle, got.scale_x,
                                     got.scale_y, got.rot, got.spin);
                        end
                    end
                end
            end
            pending = pose_q.size();
        end
    end

endmodule

[tb/sv/bone_transform_compose_tb.sv]
// testbench top for the bone transform composer: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module bone_transform_compose_tb;

    // one degree and a unit scale in the block's fixed-point formats
    localparam int DEG       = 65536;
    localparam int UNIT      = 65536;
    localparam int LATENCY   = 24;
    localparam int LIMIT     = 400000;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [26:0] ca;
        logic signed [23:0] csx;
        logic signed [23:0] csy;
        logic signed [26:0] crt;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [26:0] pa;
        logic signed [23:0] psx;
        logic signed [23:0] psy;
        logic signed [26:0] prt;
    } bone_req_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] child_x;
    logic signed [31:0] child_y;
    logic signed [26:0] child_angle;
    logic signed [23:0] child_scale_x;
    logic signed [23:0] child_scale_y;
    logic signed [26:0] child_rot_total;
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic signed [26:0] parent_angle;
    logic signed [23:0] parent_scale_x;
    logic signed [23:0] parent_scale_y;
    logic signed [26:0] parent_rot_total;
    logic               done;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [26:0] out_angle;
    logic signed [23:0] out_scale_x;
    logic signed [23:0] out_scale_y;
    logic signed [26:0] out_rot_total;
    logic signed [1:0]  spin_dir;

    int mismatches;
    int pending;
    int cycles = 0;
    // percentage of cycles in which the sender holds off
    int idle_pct = 0;

    always #4 clk = ~clk;

    bone_transform_compose dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .child_x          (child_x),
        .child_y          (child_y),
        .child_angle      (child_angle),
        .child_scale_x    (child_scale_x),
        .child_scale_y    (child_scale_y),
        .child_rot_total  (child_rot_total),
        .parent_x         (parent_x),
        .parent_y         (parent_y),
        .parent_angle     (parent_angle),
        .parent_scale_x   (parent_scale_x),
        .parent_scale_y   (parent_scale_y),
        .parent_rot_total (parent_rot_total),
        .done             (done),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_angle        (out_angle),
        .out_scale_x      (out_scale_x),
        .out_scale_y      (out_scale_y),
        .out_rot_total    (out_rot_total),
        .spin_dir         (spin_dir)
    );

    // checker watches both channels and keeps the expected poses
    compose_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .child_x          (child_x),
        .child_y          (child_y),
        .child_angle      (child_angle),
        .child_scale_x    (child_scale_x),
        .child_scale_y    (child_scale_y),
        .child_rot_total  (child_rot_total),
        .parent_x         (parent_x),
        .parent_y         (parent_y),
        .parent_angle     (parent_angle),
        .parent_scale_x   (parent_scale_x),
        .parent_scale_y   (parent_scale_y),
        .parent_rot_total (parent_rot_total),
        .done             (done),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_angle        (out_angle),
        .out_scale_x      (out_scale_x),
        .out_scale_y      (out_scale_y),
        .out_rot_total    (out_rot_total),
        .spin_dir         (spin_dir),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // uniform value in [-lim, lim]
    function automatic int spread(input int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    // plain pose: unit scales, everything else zero
    function automatic bone_req_t unit_pose();
        bone_req_t r;
        r.cx  = 0;
        r.cy  = 0;
        r.ca  = 0;
        r.csx = 24'(UNIT);
        r.csy = 24'(UNIT);
        r.crt = 0;
        r.px  = 0;
        r.py  = 0;
        r.pa  = 0;
        r.psx = 24'(UNIT);
        r.psy = 24'(UNIT);
        r.prt = 0;
        return r;
    endfunction

    function automatic bone_req_t random_pose();
        bone_req_t r;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            // raw bits everywhere, reaches saturation and the far angles
            r.cx  = $urandom();
            r.cy  = $urandom();
            r.ca  = 27'($urandom());
            r.csx = 24'($urandom());
            r.csy = 24'($urandom());
            r.crt = 27'($urandom());
            r.px  = $urandom();
            r.py  = $urandom();
            r.pa  = 27'($urandom());
            r.psx = 24'($urandom());
            r.psy = 24'($urandom());
            r.prt = 27'($urandom());
        end
        else
        begin
            // typical rig values: positions within 256 units, scales within 4
            r.cx  = spread(1 << 24);
            r.cy  = spread(1 << 24);
            r.ca  = 27'(spread(720 * DEG));
            r.csx = 24'(spread(4 * UNIT));
            r.csy = 24'(spread(4 * UNIT));
            r.crt = 27'(spread(720 * DEG));
            r.px  = spread(1 << 24);
            r.py  = spread(1 << 24);
            r.pa  = 27'(spread(720 * DEG));
            r.psx = 24'(spread(4 * UNIT));
            r.psy = 24'(spread(4 * UNIT));
            r.prt = 27'(spread(720 * DEG));
            if (pick < 45)
            begin
                // near the quadrant borders of the angle fold
                r.pa = 27'(spread(8) * 90 * DEG + spread(3));
            end
            else if (pick < 55)
            begin
                // exact unit scales with random mirroring
                r.psx = 24'($urandom_range(1) ? UNIT : -UNIT);
                r.psy = 24'($urandom_range(1) ? UNIT : -UNIT);
            end
            else if (pick < 60)
            begin
                // summed rotation cancels out
                r.crt = -r.prt;
            end
        end
        return r;
    endfunction

    task automatic issue(input bone_req_t r);
        bit stalled;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        child_x          <= r.cx;
        child_y          <= r.cy;
        child_angle      <= r.ca;
        child_scale_x    <= r.csx;
        child_scale_y    <= r.csy;
        child_rot_total  <= r.crt;
        parent_x         <= r.px;
        parent_y         <= r.py;
        parent_angle     <= r.pa;
        parent_scale_x   <= r.psx;
        parent_scale_y   <= r.psy;
        parent_rot_total <= r.prt;
        start            <= 1'b1;
        // busy is sampled away from the edge
        do
        begin
            @(negedge clk);
            stalled = busy;
            @(posedge clk);
        end
        while (stalled);
    endtask

    // hold off until every request has come back
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic random_phase(input int pct, input int count);
        idle_pct = pct;
        repeat (count)
        begin
            issue(random_pose());
        end
        drain();
    endtask

    initial
    begin
        bone_req_t r;
        rst_n            <= 1'b0;
        start            <= 1'b0;
        child_x          <= '0;
        child_y          <= '0;
        child_angle      <= '0;
        child_scale_x    <= '0;
        child_scale_y    <= '0;
        child_rot_total  <= '0;
        parent_x         <= '0;
        parent_y         <= '0;
        parent_angle     <= '0;
        parent_scale_x   <= '0;
        parent_scale_y   <= '0;
        parent_rot_total <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests, back to back
        r = unit_pose();
        r.csx = 0;
        r.csy = 0;
        r.psx = 0;
        r.psy = 0;
        issue(r);
        // identity parent
        r = unit_pose();
        r.cx = 688128;
        r.cy = -212992;
        issue(r);
        // quadrant borders and wrap of the parent angle
        r.pa = 27'(90 * DEG);
        issue(r);
        r.pa = 27'(-90 * DEG);
        issue(r);
        r.pa = 27'(180 * DEG);
        issue(r);
        r.pa = 27'(-180 * DEG);
        issue(r);
        r.pa = 27'(270 * DEG);
        issue(r);
        r.pa = 27'(36045 * DEG);
        issue(r);
        r.pa = 27'sh3ffffff;
        issue(r);
        r.pa = 27'sh4000000;
        issue(r);
        // mirroring: both negative keeps the angle, one negative flips it
        r.pa  = 27'(30 * DEG);
        r.psx = 24'(-2 * UNIT);
        r.psy = 24'(-UNIT);
        issue(r);
        r.psy = 24'(UNIT);
        issue(r);
        r.psx = 24'(UNIT);
        r.psy = 24'(-3 * UNIT);
        issue(r);
        // zero scale counts as non-negative
        r.psx = 0;
        issue(r);
        // all fields at their maximum, then at their minimum
        r = '{32'sh7fffffff, 32'sh7fffffff, 27'sh3ffffff, 24'sh7fffff, 24'sh7fffff,
              27'sh3ffffff, 32'sh7fffffff, 32'sh7fffffff, 27'sh3ffffff, 24'sh7fffff,
              24'sh7fffff, 27'sh3ffffff};
        issue(r);
        r = '{32'sh80000000, 32'sh80000000, 27'sh4000000, 24'sh800000, 24'sh800000,
              27'sh4000000, 32'sh80000000, 32'sh80000000, 27'sh4000000, 24'sh800000,
              24'sh800000, 27'sh4000000};
        issue(r);
        // scale products out of range on both sides, position sum saturating
        r = unit_pose();
        r.cx  = 32'sh40000000;
        r.cy  = -32'sh40000000;
        r.csx = 24'sh7fffff;
        r.csy = 24'sh800000;
        r.psx = 24'sh7fffff;
        r.psy = 24'sh7fffff;
        r.px  = 32'sh7fffff00;
        r.py  = 32'sh80000100;
        issue(r);
        // summed rotation zero, negative, positive
        r = unit_pose();
        r.crt = 27'(45 * DEG);
        r.prt = 27'(-45 * DEG);
        issue(r);
        r.prt = 27'(-50 * DEG);
        issue(r);
        r.prt = 1;
        issue(r);
        // angle sum overflow low, rotation overflow high
        r.ca  = 27'sh4000000;
        r.pa  = 27'(-DEG);
        r.crt = 27'sh3ffffff;
        r.prt = 27'(DEG);
        issue(r);
        drain();

        // random requests under different sender pacing
        random_phase(0, 500);
        random_phase(86, 300);
        random_phase(30, 450);
        random_phase(0, 400);

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 16) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/btc_pkg.sv
sv/btc_front.sv
sv/btc_cell.sv
sv/btc_back.sv
sv/bone_transform_compose.sv
sv/btc_checker.sv
tb/sv/compose_checker.sv
tb/sv/bone_transform_compose_tb.sv
